[hw/rtl/fdoq_pkg.sv]
// ----------------------------------------------------------------------------
// fdoq_pkg
// Shared types, sizes and the event classing table for the filtered
// drop-oldest event queue.
// ----------------------------------------------------------------------------
package fdoq_pkg;

    // Ring size and derived widths
    localparam int DEPTH   = 16;
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W  = $clog2(DEPTH + 1);

    // Fixed field widths
    localparam int KIND_W  = 4;
    localparam int CLASS_W = 3;
    localparam int HNDL_W  = 16;
    localparam int TIME_W  = 64;
    localparam int GAIN_W  = 32;
    localparam int OCC_W   = 5;
    localparam int CNT_W   = 32;

    // Operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Event kinds that the classing table singles out
    localparam logic [KIND_W-1:0] KIND_SONIFICATION = 4'd11;
    localparam logic [KIND_W-1:0] KIND_IMPACT       = 4'd12;
    localparam logic [KIND_W-1:0] KIND_VACUUM       = 4'd13;

    // Event classes
    localparam logic [CLASS_W-1:0] CLASS_REAL_ACOUSTIC = 3'd0;
    localparam logic [CLASS_W-1:0] CLASS_SONIFICATION  = 3'd1;
    localparam logic [CLASS_W-1:0] CLASS_PHYS_MODELED  = 3'd3;
    localparam logic [CLASS_W-1:0] CLASS_CINEMATIC     = 3'd5;

    // One stored ring entry
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CLASS_W-1:0] cls;
        logic               present;
        logic [HNDL_W-1:0]  handle;
        logic [TIME_W-1:0]  time_bits;
        logic [GAIN_W-1:0]  gain_bits;
    } t_entry;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // an item is accepted this cycle
    } t_cmd;

    // Result item as the datapath presents it
    typedef struct packed {
        logic               ok;
        logic [KIND_W-1:0]  out_kind;
        logic [CLASS_W-1:0] out_class;
        logic               out_subject_present;
        logic [HNDL_W-1:0]  out_subject_handle;
        logic [TIME_W-1:0]  out_time_bits;
        logic [GAIN_W-1:0]  out_gain_bits;
        logic [OCC_W-1:0]   occupancy;
        logic [CNT_W-1:0]   rejected_total;
        logic [CNT_W-1:0]   accepted_total;
    } t_result;

    // Fixed kind-to-class table
    function automatic logic [CLASS_W-1:0] class_of(input logic [KIND_W-1:0] kind);
        logic [CLASS_W-1:0] cls;
        case (kind)
            KIND_SONIFICATION: cls = CLASS_SONIFICATION;
            KIND_IMPACT:       cls = CLASS_PHYS_MODELED;
            KIND_VACUUM:       cls = CLASS_REAL_ACOUSTIC;
            default:           cls = CLASS_CINEMATIC;
        endcase
        return cls;
    endfunction

    // Admission filter: no real-acoustic class, no sonification without subject
    function automatic logic admit(input logic [CLASS_W-1:0] cls, input logic present);
        return (cls != CLASS_REAL_ACOUSTIC) && !((cls == CLASS_SONIFICATION) && !present);
    endfunction

    // Saturating counter step
    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

    // Ring pointer step
    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

[hw/rtl/fdoq_intf.sv]
// ----------------------------------------------------------------------------
// fdoq_intf
// Valid/ready channels of the event queue: event requests in, results out.
// ----------------------------------------------------------------------------

// Request channel
interface fdoq_req_if
    import fdoq_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [KIND_W-1:0]  event_kind;
    logic               subject_present;
    logic [HNDL_W-1:0]  subject_handle;
    logic [TIME_W-1:0]  time_bits;
    logic [GAIN_W-1:0]  gain_bits;

    modport source (
        output valid, opcode, event_kind, subject_present, subject_handle,
               time_bits, gain_bits,
        input  ready
    );
    modport sink (
        input  valid, opcode, event_kind, subject_present, subject_handle,
               time_bits, gain_bits,
        output ready
    );
endinterface

// Result channel
interface fdoq_rsp_if
    import fdoq_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               ok;
    logic [KIND_W-1:0]  out_kind;
    logic [CLASS_W-1:0] out_class;
    logic               out_subject_present;
    logic [HNDL_W-1:0]  out_subject_handle;
    logic [TIME_W-1:0]  out_time_bits;
    logic [GAIN_W-1:0]  out_gain_bits;
    logic [OCC_W-1:0]   occupancy;
    logic [CNT_W-1:0]   rejected_total;
    logic [CNT_W-1:0]   accepted_total;

    modport source (
        output valid, ok, out_kind, out_class, out_subject_present,
               out_subject_handle, out_time_bits, out_gain_bits, occupancy,
               rejected_total, accepted_total,
        input  ready
    );
    modport sink (
        input  valid, ok, out_kind, out_class, out_subject_present,
               out_subject_handle, out_time_bits, out_gain_bits, occupancy,
               rejected_total, accepted_total,
        output ready
    );
endinterface

[hw/rtl/fdoq_ctrl.sv]
// ----------------------------------------------------------------------------
// fdoq_ctrl
// Handshake controller: takes an item, then holds the result until taken.
// ----------------------------------------------------------------------------
module fdoq_ctrl
    import fdoq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_HOLD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    // A new item may enter when idle or when the held result leaves this cycle
    assign o_in_ready  = (r_state == S_IDLE) || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == S_HOLD);
    assign o_cmd.load  = w_accept;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_HOLD;
            end
            S_HOLD: begin
                if (i_out_ready && !w_accept) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hw/rtl/fdoq_dp.sv]
// ----------------------------------------------------------------------------
// fdoq_dp
// Datapath: entry ring, pointers, fill count, filter counters and the
// registered result.
// ----------------------------------------------------------------------------
module fdoq_dp
    import fdoq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_opcode,
    input  logic [KIND_W-1:0]  i_event_kind,
    input  logic               i_subject_present,
    input  logic [HNDL_W-1:0]  i_subject_handle,
    input  logic [TIME_W-1:0]  i_time_bits,
    input  logic [GAIN_W-1:0]  i_gain_bits,
    output t_result            o_result
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;
    t_entry w_wr_entry;

    logic [PTR_W-1:0]  r_rd_ptr,  n_rd_ptr;
    logic [PTR_W-1:0]  r_wr_ptr,  n_wr_ptr;
    logic [FILL_W-1:0] r_fill,    n_fill;
    logic [CNT_W-1:0]  r_rej_cnt, n_rej_cnt;
    logic [CNT_W-1:0]  r_acc_cnt, n_acc_cnt;
    logic              r_ok,      n_ok;
    logic              r_hit,     n_hit;

    logic [CLASS_W-1:0] w_cls;
    logic               w_admit;
    logic               w_wr_en;
    logic               w_rd_en;
    logic               w_full;
    logic               w_empty;

    // Classing and filter on the incoming event
    assign w_cls   = class_of(i_event_kind);
    assign w_admit = admit(w_cls, i_subject_present);
    assign w_full  = (r_fill == FILL_W'(DEPTH));
    assign w_empty = (r_fill == '0);

    assign w_wr_en = i_cmd.load && (i_opcode == OP_PUSH) && w_admit;
    assign w_rd_en = i_cmd.load && (i_opcode == OP_POP) && !w_empty;

    assign w_wr_entry = '{kind:      i_event_kind,
                          cls:       w_cls,
                          present:   i_subject_present,
                          handle:    i_subject_handle,
                          time_bits: i_time_bits,
                          gain_bits: i_gain_bits};

    // Pointer, fill and counter updates
    always_comb begin
        n_rd_ptr  = r_rd_ptr;
        n_wr_ptr  = r_wr_ptr;
        n_fill    = r_fill;
        n_rej_cnt = r_rej_cnt;
        n_acc_cnt = r_acc_cnt;
        n_ok      = r_ok;
        n_hit     = r_hit;
        if (i_cmd.load) begin
            if (i_opcode == OP_PUSH) begin
                n_ok  = w_admit;
                n_hit = 1'b0;
                if (!w_admit) begin
                    n_rej_cnt = bump(r_rej_cnt);
                end else begin
                    n_acc_cnt = bump(r_acc_cnt);
                    n_wr_ptr  = advance(r_wr_ptr);
                    // Full ring: oldest entry is dropped, occupancy stays
                    if (w_full) n_rd_ptr = advance(r_rd_ptr);
                    else        n_fill   = r_fill + 1'b1;
                end
            end else begin
                n_ok  = !w_empty;
                n_hit = !w_empty;
                if (!w_empty) begin
                    n_rd_ptr = advance(r_rd_ptr);
                    n_fill   = r_fill - 1'b1;
                end
            end
        end
    end

    // Control and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr  <= '0;
            r_wr_ptr  <= '0;
            r_fill    <= '0;
            r_rej_cnt <= '0;
            r_acc_cnt <= '0;
            r_ok      <= 1'b0;
            r_hit     <= 1'b0;
        end else begin
            r_rd_ptr  <= n_rd_ptr;
            r_wr_ptr  <= n_wr_ptr;
            r_fill    <= n_fill;
            r_rej_cnt <= n_rej_cnt;
            r_acc_cnt <= n_acc_cnt;
            r_ok      <= n_ok;
            r_hit     <= n_hit;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[r_wr_ptr] <= w_wr_entry;
        if (w_rd_en) r_rd_data <= r_mem[r_rd_ptr];
    end

    // Result; popped fields read zero unless a pop returned an entry
    assign o_result.ok                  = r_ok;
    assign o_result.out_kind            = r_hit ? r_rd_data.kind      : '0;
    assign o_result.out_class           = r_hit ? r_rd_data.cls       : '0;
    assign o_result.out_subject_present = r_hit && r_rd_data.present;
    assign o_result.out_subject_handle  = r_hit ? r_rd_data.handle    : '0;
    assign o_result.out_time_bits       = r_hit ? r_rd_data.time_bits : '0;
    assign o_result.out_gain_bits       = r_hit ? r_rd_data.gain_bits : '0;
    assign o_result.occupancy           = OCC_W'(r_fill);
    assign o_result.rejected_total      = r_rej_cnt;
    assign o_result.accepted_total      = r_acc_cnt;

endmodule

[hw/rtl/filtered_drop_oldest_event_queue_unit.sv]
// ----------------------------------------------------------------------------
// filtered_drop_oldest_event_queue_unit
// Event queue with an admission filter and drop-oldest overflow.
//
//   Channel   Dir  Handshake         Carries
//   i_evt     in   valid / ready     opcode, kind, subject, time, gain
//   o_res     out  valid / ready     ok, popped entry, occupancy, counters
//
// One result per item, valid the cycle after the item is taken; the result
// and the controller state are both registered.
// Sustained rate is one item per cycle while results are taken at once.
// A stalled result holds; a new item is taken in the cycle it leaves.
// Synchronous active-low reset empties the ring and clears both counters.
// ----------------------------------------------------------------------------
module filtered_drop_oldest_event_queue_unit
    import fdoq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    fdoq_req_if.sink   i_evt,
    fdoq_rsp_if.source o_res
);

    t_cmd    w_cmd;
    t_result w_result;

    // Handshake controller
    fdoq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_evt.valid),
        .i_out_ready (o_res.ready),
        .o_in_ready  (i_evt.ready),
        .o_out_valid (o_res.valid),
        .o_cmd       (w_cmd)
    );

    // Ring and counters
    fdoq_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_opcode          (i_evt.opcode),
        .i_event_kind      (i_evt.event_kind),
        .i_subject_present (i_evt.subject_present),
        .i_subject_handle  (i_evt.subject_handle),
        .i_time_bits       (i_evt.time_bits),
        .i_gain_bits       (i_evt.gain_bits),
        .o_result          (w_result)
    );

    // Result payload
    assign o_res.ok                  = w_result.ok;
    assign o_res.out_kind            = w_result.out_kind;
    assign o_res.out_class           = w_result.out_class;
    assign o_res.out_subject_present = w_result.out_subject_present;
    assign o_res.out_subject_handle  = w_result.out_subject_handle;
    assign o_res.out_time_bits       = w_result.out_time_bits;
    assign o_res.out_gain_bits       = w_result.out_gain_bits;
    assign o_res.occupancy           = w_result.occupancy;
    assign o_res.rejected_total      = w_result.rejected_total;
    assign o_res.accepted_total      = w_result.accepted_total;

endmodule
